/* rtl/pifd_pkg.sv */
// Shared types and constants of the packed integer field decoder.
`default_nettype none

package pifd_pkg;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // Register indexes (word address bits 3:2)
    localparam logic [1:0] REG_FIELD_WIDTH   = 2'd0;
    localparam logic [1:0] REG_NUMBER_FORMAT = 2'd1;
    localparam logic [1:0] REG_BYTE_ORDER    = 2'd2;

    // Number format codes
    localparam logic [1:0] FMT_UNSIGNED = 2'd0;
    localparam logic [1:0] FMT_SIGNED   = 2'd1;
    localparam logic [1:0] FMT_BCD      = 2'd2;
    localparam logic [1:0] FMT_RESERVED = 2'd3;

    // Byte order codes
    localparam logic ORDER_LITTLE = 1'b0;
    localparam logic ORDER_BIG    = 1'b1;

    localparam logic [6:0] FIELD_WIDTH_RESET = 7'd8;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BEYOND   = 3'd1,
        ST_CROSS    = 3'd2,
        ST_MISALIGN = 3'd3,
        ST_UNSUP    = 3'd4
    } status_t;

    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  top_bit;
        logic [15:0] bits_available;
    } in_item_t;

    typedef struct packed {
        logic signed [32:0] decoded_value;
        status_t            status;
    } out_item_t;

    typedef struct packed {
        logic [6:0] field_width;
        logic [1:0] number_format;
        logic       byte_order;
    } cfg_t;

endpackage

`default_nettype wire

/* rtl/pifd_regs.sv */
// APB configuration registers of the packed integer field decoder.
`default_nettype none

module pifd_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [pifd_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [pifd_pkg::DATA_W-1:0]   pwdata,
    output logic      [pifd_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    output pifd_pkg::cfg_t                     cfg
);
    import pifd_pkg::*;

    logic [6:0] field_width_reg;
    logic [1:0] number_format_reg;
    logic       byte_order_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_width_reg   <= FIELD_WIDTH_RESET;
            number_format_reg <= FMT_UNSIGNED;
            byte_order_reg    <= ORDER_LITTLE;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_FIELD_WIDTH:   field_width_reg   <= pwdata[6:0];
                REG_NUMBER_FORMAT: number_format_reg <= pwdata[1:0];
                REG_BYTE_ORDER:    byte_order_reg    <= pwdata[0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_FIELD_WIDTH:   prdata = {25'd0, field_width_reg};
            REG_NUMBER_FORMAT: prdata = {30'd0, number_format_reg};
            REG_BYTE_ORDER:    prdata = {31'd0, byte_order_reg};
            default:           prdata = '0;
        endcase
    end

    assign cfg.field_width   = field_width_reg;
    assign cfg.number_format = number_format_reg;
    assign cfg.byte_order    = byte_order_reg;

endmodule

`default_nettype wire

/* rtl/pifd_decode.sv */
// Combinational field decode: bounds and width checks, extract, byte order, BCD.
`default_nettype none

module pifd_decode (
    input  pifd_pkg::in_item_t  item,
    input  pifd_pkg::cfg_t      cfg,
    output pifd_pkg::out_item_t result
);
    import pifd_pkg::*;

    logic [6:0]  w;
    logic [3:0]  top1;
    logic [3:0]  sh;
    logic [7:0]  mask;
    logic [7:0]  narrow_val;
    logic        is16;
    logic [15:0] ord16;
    logic [31:0] ord32;
    logic [3:0]  nib [8];
    logic [3:0]  dig [8];
    logic [7:0]  pair [4];
    logic [14:0] quad [2];
    logic [27:0] bcd_acc;
    logic [32:0] wide_val;
    logic [32:0] value;
    status_t     status;

    assign w    = cfg.field_width;
    assign top1 = {1'b0, item.top_bit} + 4'd1;
    assign is16 = (w == 7'd16);

    assign ord16 = (cfg.byte_order == ORDER_BIG) ?
                   {item.data_word[7:0], item.data_word[15:8]} : item.data_word[15:0];
    assign ord32 = (cfg.byte_order == ORDER_BIG) ?
                   {item.data_word[7:0], item.data_word[15:8],
                    item.data_word[23:16], item.data_word[31:24]} : item.data_word;

    // Narrow extract out of the first byte
    always_comb
    begin
        sh         = top1 - w[3:0];
        mask       = 8'((9'd1 << w[3:0]) - 9'd1);
        narrow_val = (item.data_word[7:0] >> sh) & mask;
    end

    // Order digits most significant first, then weight them in a short tree:
    // digit pairs, pairs of pairs, and the two halves of the word
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            nib[i] = item.data_word[4*i +: 4];
        end
        for (int k = 0; k < 8; k++)
        begin
            if (cfg.byte_order == ORDER_LITTLE)
                dig[k] = nib[k];
            else if (is16)
                dig[k] = nib[(3 - k) & 3];
            else
                dig[k] = nib[7 - k];
        end
        for (int j = 0; j < 4; j++)
        begin
            pair[j] = ({4'd0, dig[2*j]} << 3) + ({4'd0, dig[2*j]} << 1) +
                      {4'd0, dig[2*j+1]};
        end
        for (int j = 0; j < 2; j++)
        begin
            quad[j] = {7'd0, pair[2*j]} * 15'd100 + {7'd0, pair[2*j+1]};
        end
        if (is16)
            bcd_acc = {13'd0, quad[0]};
        else
            bcd_acc = {13'd0, quad[0]} * 28'd10000 + {13'd0, quad[1]};
    end

    always_comb
    begin
        if (cfg.number_format == FMT_BCD)
            wide_val = {5'd0, bcd_acc};
        else if (is16)
            wide_val = (cfg.number_format == FMT_SIGNED) ?
                       {{17{ord16[15]}}, ord16} : {17'd0, ord16};
        else
            wide_val = (cfg.number_format == FMT_SIGNED) ?
                       {ord32[31], ord32} : {1'b0, ord32};
    end

    always_comb
    begin
        status = ST_OK;
        value  = '0;
        if ({9'd0, w} > item.bits_available)
            status = ST_BEYOND;
        else if (w <= 7'd8)
        begin
            if (top1 < w[3:0])
                status = ST_CROSS;
            else
                value = {25'd0, narrow_val};
        end
        else if (w > 7'd32)
            status = ST_UNSUP;
        else if (item.top_bit != 3'd7)
            status = ST_MISALIGN;
        else if (cfg.number_format == FMT_RESERVED)
            status = ST_UNSUP;
        else
            value = wide_val;
    end

    assign result.decoded_value = value;
    assign result.status        = status;

endmodule

`default_nettype wire

/* rtl/packed_integer_field_decoder_core.sv */
// Top level of the packed integer field decoder: request and result registers.
//
//  Channel  | Handshake              | Payload
//  ---------+------------------------+---------------------------------------
//  in       | in_valid / in_ready    | in_data  (data_word, top_bit, bits_available)
//  out      | out_valid / out_ready  | out_data (decoded_value, status)
//  config   | APB psel/penable/...   | field_width, number_format, byte_order
//
//  A request is captured in the request register, decoded, and loaded into the
//  result register that drives out_data; one request is taken every cycle unless
//  both registers are full and the output stalls. Reset clears both valid flags
//  and loads the register defaults (width 8, unsigned, little endian). A stalled
//  result holds in the result register while the request register still takes one more request.
`default_nettype none

module packed_integer_field_decoder_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  pifd_pkg::in_item_t                 in_data,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output pifd_pkg::out_item_t                out_data,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [pifd_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [pifd_pkg::DATA_W-1:0]   pwdata,
    output logic      [pifd_pkg::DATA_W-1:0]   prdata,
    output logic                               pready
);
    import pifd_pkg::*;

    cfg_t      cfg;
    in_item_t  req_reg;
    logic      req_valid_reg;
    out_item_t res_reg;
    out_item_t res_next;
    logic      res_valid_reg;
    logic      res_load;

    pifd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pifd_decode u_decode (
        .item   (req_reg),
        .cfg    (cfg),
        .result (res_next)
    );

    // Advance the result stage whenever it is empty or being drained
    assign res_load = !res_valid_reg || out_ready;
    // Take a new request whenever the request stage is empty or moving on
    assign in_ready = !req_valid_reg || res_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                req_valid_reg <= in_valid;
            if (res_load)
                res_valid_reg <= req_valid_reg;
        end
    end

    // Payload registers: load only on a real handoff
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            req_reg <= in_data;
        if (res_load && req_valid_reg)
            res_reg <= res_next;
    end

    assign out_valid = res_valid_reg;
    assign out_data  = res_reg;

    // A failed decode never carries a value
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.status != ST_OK) |-> (res_reg.decoded_value == '0))
        else $error("nonzero value with failing status");

    // Back-pressure only when both stages are full and the output stalls
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (req_valid_reg && res_valid_reg && !out_ready))
        else $error("request refused with room in the pipeline");

    // A pending request reaches the result stage when it opens
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid_reg && res_load) |=> res_valid_reg)
        else $error("request lost between stages");

    // A stalled result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !out_ready) |=> (res_valid_reg && $stable(res_reg)))
        else $error("stalled result changed");

endmodule

`default_nettype wire
